FILE: rtl/dsm2_pkg.sv
// ----------------------------------------------------------------------------
// dsm2_pkg
// Shared types and constants for the serial satellite frame decoder.
// ----------------------------------------------------------------------------
package dsm2_pkg;

    // Frame tracking: skip byte, first byte of a pair, second byte of a pair
    typedef enum logic [1:0] {
        PHASE_NEW    = 2'd0,
        PHASE_FIRST  = 2'd1,
        PHASE_SECOND = 2'd2
    } phase_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_RESOLUTION = 2'd0,
        CFG_GAP        = 2'd1,
        CFG_ORDER      = 2'd2
    } cfg_index_t;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned GAP_W       = 16;
    localparam int unsigned CHAN_W      = 4;
    localparam int unsigned VALUE_W     = 11;
    localparam int unsigned ORDER_COUNT = 12;
    localparam int unsigned ORDER_W     = ORDER_COUNT * CHAN_W;

    localparam logic [CHAN_W-1:0]  CHAN_MASK      = 4'h0F;
    localparam logic [2:0]         HIGH_MASK_1024 = 3'h3;
    localparam logic [2:0]         HIGH_MASK_2048 = 3'h7;
    localparam logic [2:0]         SHIFT_1024     = 3'd2;
    localparam logic [2:0]         SHIFT_2048     = 3'd3;

    localparam logic               RESOLUTION_RESET = 1'b0;
    localparam logic [GAP_W-1:0]   GAP_RESET        = 16'd5000;
    localparam logic [ORDER_W-1:0] ORDER_RESET      = 48'hBA9876543210;

    // Decoded result of one completed byte pair
    typedef struct packed {
        logic               update_valid;
        logic [CHAN_W-1:0]  dest_channel;
        logic [VALUE_W-1:0] channel_value;
        logic               failsafe_kick;
    } pair_result_t;

endpackage

FILE: rtl/dsm2_serial_frame_decoder.sv
// ----------------------------------------------------------------------------
// dsm2_serial_frame_decoder
// Serial satellite receiver frame decoder: byte pairs to channel updates.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake              | Payload
//  --------+------------------------+-----------------------------------------
//  in      | in_valid / in_stall    | rx_byte, gap_us
//  out     | out_valid / out_stall  | update_valid, dest_channel,
//          |                        | channel_value, failsafe_kick
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  One request in, one result out; the result is registered and appears in
//  the cycle after its byte is taken; a new byte is taken every cycle while results drain.
//  Frame state updates at the accepting edge, so back-to-back bytes see it.
//  in_stall follows a full result register that downstream is stalling.
//  Reset (rst_n, async) restores the register defaults and a fresh frame.
//  Config writes always complete (cfg_ready held high); index 3 is ignored.
//
module dsm2_serial_frame_decoder #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [dsm2_pkg::BYTE_W-1:0]  rx_byte,
    input  logic [dsm2_pkg::GAP_W-1:0]   gap_us,

    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         update_valid,
    output logic [dsm2_pkg::CHAN_W-1:0]  dest_channel,
    output logic [dsm2_pkg::VALUE_W-1:0] channel_value,
    output logic                         failsafe_kick,

    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [1:0]                   cfg_index,
    input  logic [dsm2_pkg::ORDER_W-1:0] cfg_data
);

    // configuration registers
    logic                         resolution_reg;
    logic [dsm2_pkg::GAP_W-1:0]   gap_threshold_reg;
    logic [dsm2_pkg::ORDER_W-1:0] order_reg;

    // frame state
    dsm2_pkg::phase_t             phase_reg, phase_next;
    logic [dsm2_pkg::BYTE_W-1:0]  held_reg, held_next;

    // result register
    logic                         out_valid_reg;
    dsm2_pkg::pair_result_t       result_reg, result_next;
    dsm2_pkg::pair_result_t       pair_result;

    logic                         in_accept;
    logic                         out_accept;
    logic                         long_gap;

    assign cfg_ready  = 1'b1;
    assign out_accept = out_valid_reg && !out_stall;
    assign in_stall   = out_valid_reg && out_stall;
    assign in_accept  = in_valid && !in_stall;
    assign long_gap   = (gap_us > gap_threshold_reg);

    // ---- configuration writes ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resolution_reg    <= dsm2_pkg::RESOLUTION_RESET;
            gap_threshold_reg <= dsm2_pkg::GAP_RESET;
            order_reg         <= dsm2_pkg::ORDER_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (dsm2_pkg::cfg_index_t'(cfg_index))
                dsm2_pkg::CFG_RESOLUTION: resolution_reg    <= cfg_data[0];
                dsm2_pkg::CFG_GAP:        gap_threshold_reg <= cfg_data[dsm2_pkg::GAP_W-1:0];
                dsm2_pkg::CFG_ORDER:      order_reg         <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---- pair decode ----
    dsm2_pair_decode #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_pair_decode (
        .held_byte       (held_reg),
        .low_byte        (rx_byte),
        .resolution_mode (resolution_reg),
        .channel_order   (order_reg),
        .result          (pair_result)
    );

    // ---- frame tracking: next state and result ----
    always_comb
    begin
        phase_next  = phase_reg;
        held_next   = held_reg;
        result_next = '0;
        if (long_gap)
        begin
            // this byte is skipped too
            phase_next = dsm2_pkg::PHASE_NEW;
        end
        else
        begin
            case (phase_reg)
                dsm2_pkg::PHASE_NEW:
                begin
                    phase_next = dsm2_pkg::PHASE_FIRST;
                end
                dsm2_pkg::PHASE_FIRST:
                begin
                    held_next  = rx_byte;
                    phase_next = dsm2_pkg::PHASE_SECOND;
                end
                default:
                begin
                    // second byte completes the pair (unused code acts alike)
                    result_next = pair_result;
                    phase_next  = dsm2_pkg::PHASE_FIRST;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= dsm2_pkg::PHASE_NEW;
            held_reg  <= '0;
        end
        else if (in_accept)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

    // ---- result register ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_accept)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign update_valid  = result_reg.update_valid;
    assign dest_channel  = result_reg.dest_channel;
    assign channel_value = result_reg.channel_value;
    assign failsafe_kick = result_reg.failsafe_kick;

endmodule

FILE: rtl/dsm2_pair_decode.sv
// ----------------------------------------------------------------------------
// dsm2_pair_decode
// Splits a byte pair into channel number and value, remaps the channel.
// ----------------------------------------------------------------------------
module dsm2_pair_decode #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic [dsm2_pkg::BYTE_W-1:0]  held_byte,
    input  logic [dsm2_pkg::BYTE_W-1:0]  low_byte,
    input  logic                         resolution_mode,
    input  logic [dsm2_pkg::ORDER_W-1:0] channel_order,
    output dsm2_pkg::pair_result_t       result
);

    logic [dsm2_pkg::BYTE_W-1:0] shifted;
    logic [dsm2_pkg::CHAN_W-1:0] chan;
    logic [2:0]                  high_bits;
    logic [dsm2_pkg::CHAN_W-1:0] dest;
    logic                        in_range;

    always_comb
    begin
        shifted   = held_byte >> (resolution_mode ? dsm2_pkg::SHIFT_2048
                                                  : dsm2_pkg::SHIFT_1024);
        chan      = shifted[dsm2_pkg::CHAN_W-1:0] & dsm2_pkg::CHAN_MASK;
        high_bits = held_byte[2:0] & (resolution_mode ? dsm2_pkg::HIGH_MASK_2048
                                                      : dsm2_pkg::HIGH_MASK_1024);
        in_range  = (chan < dsm2_pkg::CHAN_W'(NUM_CHANNELS));

        // remap mux over the order table entries
        dest = '0;
        for (int i = 0; i < dsm2_pkg::ORDER_COUNT; i++)
        begin
            if (chan == dsm2_pkg::CHAN_W'(i))
            begin
                dest = channel_order[i*dsm2_pkg::CHAN_W +: dsm2_pkg::CHAN_W];
            end
        end

        result.failsafe_kick = 1'b1;
        result.update_valid  = in_range;
        result.dest_channel  = in_range ? dest : '0;
        result.channel_value = in_range ? {high_bits, low_byte} : '0;
    end

endmodule

FILE: sim/tb_dsm2_serial_frame_decoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dsm2_serial_frame_decoder
// Self-checking bench for the serial satellite frame decoder. A queue-fed
// driver sends byte requests under random flow control, a clocked monitor
// checks every result field against a cycle-free decoder kept in the bench,
// and the register set is changed between traffic phases.
// ----------------------------------------------------------------------------
module tb_dsm2_serial_frame_decoder;

    localparam int N_CH = 8;
    localparam int N_PHASES = 8;
    localparam int PHASE_BUDGET = 58;       // random requests per phase
    localparam logic [1:0] CFG_UNUSED = 2'd3;  // decoder ignores this index

    // One byte request as the sender presents it
    typedef struct {
        logic [dsm2_pkg::BYTE_W-1:0] data;
        logic [dsm2_pkg::GAP_W-1:0]  gap;
    } rx_req_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic [dsm2_pkg::BYTE_W-1:0]   rx_byte = '0;
    logic [dsm2_pkg::GAP_W-1:0]    gap_us = '0;

    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic                          update_valid;
    logic [dsm2_pkg::CHAN_W-1:0]   dest_channel;
    logic [dsm2_pkg::VALUE_W-1:0]  channel_value;
    logic                          failsafe_kick;

    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [1:0]                    cfg_index = '0;
    logic [dsm2_pkg::ORDER_W-1:0]  cfg_data = '0;

    // Bench-side copy of the registers, written alongside every config write
    logic                          cur_mode = dsm2_pkg::RESOLUTION_RESET;
    logic [dsm2_pkg::GAP_W-1:0]    cur_gap_limit = dsm2_pkg::GAP_RESET;
    logic [dsm2_pkg::ORDER_W-1:0]  cur_order = dsm2_pkg::ORDER_RESET;

    // Bench-side frame tracker
    dsm2_pkg::phase_t              frame_pos = dsm2_pkg::PHASE_NEW;
    logic [dsm2_pkg::BYTE_W-1:0]   held_byte = '0;

    rx_req_t                       pending_q[$];  // requests waiting for the driver
    dsm2_pkg::pair_result_t        decoded_q[$];  // decoder results not yet seen

    logic                          in_fire = 1'b0; // request taken at the last rising edge
    int                            send_idle_pct = 0;
    int                            stall_pct = 0;

    int                            n_queued = 0;
    int                            n_checked = 0;
    int                            n_errors = 0;
    int                            n_updates = 0;
    int                            n_dropped = 0;

    always #4 clk = ~clk;

    dsm2_serial_frame_decoder #(
        .NUM_CHANNELS (N_CH)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .gap_us        (gap_us),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .update_valid  (update_valid),
        .dest_channel  (dest_channel),
        .channel_value (channel_value),
        .failsafe_kick (failsafe_kick),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // ------------------------------------------------------------------
    // Decoder: advances the frame tracker by one byte and returns what the
    // block must report for it. Every byte yields exactly one result.
    // ------------------------------------------------------------------
    function automatic dsm2_pkg::pair_result_t decode_next_byte(
        logic [dsm2_pkg::BYTE_W-1:0] b,
        logic [dsm2_pkg::GAP_W-1:0] g);
        dsm2_pkg::pair_result_t r;
        logic [dsm2_pkg::CHAN_W-1:0] ch;
        r = '0;
        if (g > cur_gap_limit)
        begin
            // long silence: this byte opens a frame and is itself skipped
            frame_pos = dsm2_pkg::PHASE_NEW;
        end
        else if (frame_pos == dsm2_pkg::PHASE_NEW)
        begin
            frame_pos = dsm2_pkg::PHASE_FIRST;  // second header byte, skipped
        end
        else if (frame_pos == dsm2_pkg::PHASE_FIRST)
        begin
            held_byte = b;
            frame_pos = dsm2_pkg::PHASE_SECOND;
        end
        else
        begin
            ch = cur_mode ? held_byte[6:3] : held_byte[5:2];
            if (ch < N_CH)
            begin
                r.update_valid  = 1'b1;
                r.dest_channel  = cur_order[4*ch +: 4];
                r.channel_value = cur_mode ? {held_byte[2:0], b}
                                           : {1'b0, held_byte[1:0], b};
            end
            // out-of-range channels are dropped but still kick the failsafe
            r.failsafe_kick = 1'b1;
            frame_pos = dsm2_pkg::PHASE_FIRST;
        end
        return r;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            n_errors++;
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: checks results and records accepted requests, both at the
    // rising edge. Results are compared before the new request is decoded,
    // so a result can never be matched against its own cycle's request.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor_blk
        dsm2_pkg::pair_result_t want;
        if (rst_n)
        begin
            in_fire <= in_valid && !in_stall;
            if (out_valid && !out_stall)
            begin
                if (decoded_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got %0h", $time,
                             {update_valid, dest_channel, channel_value, failsafe_kick});
                    n_errors++;
                end
                else
                begin
                    want = decoded_q.pop_front();
                    check_field("update_valid", 32'(want.update_valid), 32'(update_valid));
                    check_field("dest_channel", 32'(want.dest_channel), 32'(dest_channel));
                    check_field("channel_value", 32'(want.channel_value),
                                32'(channel_value));
                    check_field("failsafe_kick", 32'(want.failsafe_kick),
                                32'(failsafe_kick));
                    if (want.update_valid)
                        n_updates++;
                    else if (want.failsafe_kick)
                        n_dropped++;
                end
                n_checked++;
            end
            if (in_valid && !in_stall)
                decoded_q.push_back(decode_next_byte(rx_byte, gap_us));
        end
    end

    // ------------------------------------------------------------------
    // Driver: moves to a new request only once the current one was taken,
    // so a stalled payload holds. Receiver stall is redrawn every cycle.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : driver_blk
        rx_req_t req;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            out_stall <= 1'b0;
        end
        else
        begin
            if (!in_valid || in_fire)
            begin
                if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    req = pending_q.pop_front();
                    in_valid <= 1'b1;
                    rx_byte  <= req.data;
                    gap_us   <= req.gap;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_byte(logic [dsm2_pkg::BYTE_W-1:0] b, logic [dsm2_pkg::GAP_W-1:0] g);
        rx_req_t req;
        req.data = b;
        req.gap  = g;
        pending_q.push_back(req);
        n_queued++;
    endtask

    function automatic logic [dsm2_pkg::ORDER_W-1:0] rand_order();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[dsm2_pkg::ORDER_W-1:0];
    endfunction

    // Register writes happen only with the decoder drained
    task automatic write_reg(logic [1:0] idx, logic [dsm2_pkg::ORDER_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            dsm2_pkg::CFG_RESOLUTION: cur_mode = data[0];
            dsm2_pkg::CFG_GAP:        cur_gap_limit = data[dsm2_pkg::GAP_W-1:0];
            dsm2_pkg::CFG_ORDER:      cur_order = data;
            default:                  ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Upper data bits are junk on the narrow registers; only the low bits count
    task automatic set_regs(logic mode, logic [dsm2_pkg::GAP_W-1:0] limit,
                            logic [dsm2_pkg::ORDER_W-1:0] order);
        logic [dsm2_pkg::ORDER_W-1:0] junk;
        junk = rand_order();
        write_reg(dsm2_pkg::CFG_RESOLUTION, {junk[dsm2_pkg::ORDER_W-1:1], mode});
        junk = rand_order();
        write_reg(dsm2_pkg::CFG_GAP, {junk[dsm2_pkg::ORDER_W-1:dsm2_pkg::GAP_W], limit});
        write_reg(dsm2_pkg::CFG_ORDER, order);
    endtask

    // Wait until every queued request has produced its checked result,
    // then idle on to let the one-deep result register settle
    task automatic drain();
        while (n_checked < n_queued) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic logic [dsm2_pkg::GAP_W-1:0] in_frame_gap();
        if ($urandom_range(0, 1))
            return 16'($urandom_range(0, cur_gap_limit));
        return 16'($urandom_range(0, cur_gap_limit < 50 ? cur_gap_limit : 50));
    endfunction

    function automatic logic [dsm2_pkg::GAP_W-1:0] frame_gap();
        if (cur_gap_limit == '1)
            return '1;                          // no gap can open a frame here
        return 16'($urandom_range(cur_gap_limit + 1, 65535));
    endfunction

    // First byte of a pair: mostly a live channel, sometimes any channel, which may lie beyond range
    function automatic logic [dsm2_pkg::BYTE_W-1:0] pair_head();
        logic [dsm2_pkg::BYTE_W-1:0] b;
        logic [dsm2_pkg::CHAN_W-1:0] ch;
        b  = 8'($urandom);
        ch = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(0, N_CH - 1))
                                         : 4'($urandom_range(0, 15));
        if (cur_mode)
            b[6:3] = ch;
        else
            b[5:2] = ch;
        return b;
    endfunction

    // Frames with random content; some are cut short or end mid-pair,
    // and about one draw in ten is a single byte of unstructured noise
    task automatic queue_traffic(int budget);
        int start;
        int pairs;
        start = n_queued;
        while (n_queued - start < budget)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                queue_byte(8'($urandom), 16'($urandom));
            end
            else
            begin
                pairs = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 7;
                queue_byte(8'($urandom), frame_gap());
                queue_byte(8'($urandom), in_frame_gap());
                repeat (pairs)
                begin
                    queue_byte(pair_head(), in_frame_gap());
                    queue_byte(8'($urandom), in_frame_gap());
                end
                if ($urandom_range(0, 4) == 0)
                    queue_byte(pair_head(), in_frame_gap());
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence: reset, then phases that each pick a flow-control
    // pattern and a register setting, with directed bytes up front in the
    // first two phases
    initial
    begin : stimulus_blk
        int p;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (p = 0; p < N_PHASES; p++)
        begin
            // registers: reset values first, then extremes and random picks
            case (p)
                1: set_regs(1'b1, 16'($urandom_range(100, 60000)), rand_order());
                2: set_regs(1'b0, 16'h0000, 48'hFFFF_FFFF_FFFF);
                3: set_regs(1'b1, 16'hFFFF, 48'h0);
                4:
                begin
                    set_regs(1'b0, 16'h0001, rand_order());
                    write_reg(CFG_UNUSED, rand_order());
                end
                5: set_regs(1'b1, 16'hFFFE, rand_order());
                6: set_regs(1'b0, 16'($urandom), rand_order());
                7: set_regs(1'b1, 16'($urandom), rand_order());
                default: ;
            endcase

            // flow control: none, sender idle, receiver stall, both
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;  stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 68; stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;  stall_pct = 68;
                end
                default:
                begin
                    send_idle_pct = 32; stall_pct = 32;
                end
            endcase

            if (p == 0)
            begin
                // 10-bit mode, threshold 5000, identity order
                queue_byte(8'hFF, 16'hFFFF);    // frame start, skipped
                queue_byte(8'h00, 16'h0000);    // second header byte
                queue_byte(8'h03, 16'd5000);    // gap at threshold stays in frame
                queue_byte(8'hFF, 16'h0000);    // channel 0, full-scale value
                queue_byte(8'hDC, 16'd17);      // channel 7, top bits set
                queue_byte(8'h00, 16'd4999);    // zero value
                queue_byte(8'h20, 16'd2);       // channel 8: dropped
                queue_byte(8'h55, 16'd3);
                queue_byte(8'h3F, 16'd1);       // channel 15: dropped
                queue_byte(8'hAA, 16'd1);
                queue_byte(8'h04, 16'd1);       // pair head, then
                queue_byte(8'h12, 16'd5001);    // gap just over threshold mid-pair
                queue_byte(8'h34, 16'd1);
                queue_byte(8'h0A, 16'd4999);
                queue_byte(8'h80, 16'h0000);
            end
            else if (p == 1)
            begin
                // 11-bit mode extremes
                queue_byte(8'h00, 16'hFFFF);
                queue_byte(8'hFF, 16'h0000);
                queue_byte(8'h07, 16'h0000);    // channel 0, full-scale value
                queue_byte(8'hFF, 16'h0000);
                queue_byte(8'hB9, 16'h0000);    // channel 7 with bit 7 set
                queue_byte(8'h01, 16'h0000);
                queue_byte(8'hFF, 16'h0000);    // channel 15: dropped
                queue_byte(8'h00, 16'h0000);
            end

            queue_traffic(PHASE_BUDGET);
            drain();
        end

        if (decoded_q.size() != 0)
        begin
            $display("%0t: %0d results missing, expected more, got none", $time,
                     decoded_q.size());
            n_errors++;
        end

        $display("Sent %0d bytes across %0d register settings and 4 flow-control patterns;",
                 n_queued, N_PHASES);
        $display("checked %0d results: %0d channel updates, %0d dropped channels, %0d errors.",
                 n_checked, n_updates, n_dropped, n_errors);
        if (n_errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin : watchdog_blk
        #2000000;
        $display("Timeout with %0d of %0d results checked", n_checked, n_queued);
        $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: dsm2_serial_frame_decoder.f
rtl/dsm2_pkg.sv
rtl/dsm2_pair_decode.sv
rtl/dsm2_serial_frame_decoder.sv
sim/tb_dsm2_serial_frame_decoder.sv
